>>> hw/rtl/dts_pkg.sv
// shared constants, types and helpers of the delimited token splitter
package dts_pkg;

	localparam int MAX_LEN = 4096;
	localparam int SEP_MAX = 8;
	localparam int POS_W   = $clog2(MAX_LEN + 1);
	localparam int SLOT_W  = $clog2(SEP_MAX);
	localparam int LEN_W   = 4;
	localparam int START_W = 12;
	localparam int PLEN_W  = 13;
	localparam int SEPB_W  = 8 * SEP_MAX;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [SEPB_W-1:0] SEP_BYTES_RST  = SEPB_W'(44);
	localparam logic [LEN_W-1:0]  SEP_LENGTH_RST = LEN_W'(1);

	typedef enum logic {
		REG_SEP_BYTES  = 1'b0,
		REG_SEP_LENGTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data;
		logic       txt;
	} slot_t;

	typedef struct packed {
		logic               piece_valid;
		logic [START_W-1:0] piece_start;
		logic [PLEN_W-1:0]  piece_length;
		logic               end_of_value;
		logic               any_piece;
		logic               overflow;
	} result_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB);
	endfunction

endpackage

>>> hw/rtl/dts_cell.sv
// one window slot: holds a byte and its in-piece text mark, shifts to its neighbor
module dts_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          clr_txt,
	input  logic          need,
	input  logic [7:0]    want,
	input  dts_pkg::slot_t prev,
	output dts_pkg::slot_t cur,
	output logic          eq
);
	import dts_pkg::*;

	logic [7:0] data_q;
	logic       txt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_q <= 1'b0;
		end else if (clr_txt) begin
			txt_q <= 1'b0;
		end else if (shift) begin
			txt_q <= prev.txt;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= prev.data;
		end
	end

	// compare the byte that lands in this slot on a shift
	assign eq       = !need || (prev.data == want);
	assign cur.data = data_q;
	assign cur.txt  = txt_q;

endmodule

>>> hw/rtl/dts_out_skid.sv
// result register with a skid entry so the input side keeps flowing
module dts_out_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dts_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	output dts_pkg::result_t out_data,
	input  logic             out_stall
);
	import dts_pkg::*;

	logic    out_vld_q;
	logic    skd_vld_q;
	result_t out_q;
	result_t skd_q;
	logic    pop;

	assign pop = out_vld_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (skd_vld_q) begin
			if (pop) begin
				skd_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_vld_q || pop) begin
				out_vld_q <= 1'b1;
			end else begin
				skd_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skd_vld_q) begin
			if (pop) begin
				out_q <= skd_q;
			end
		end else if (push) begin
			if (!out_vld_q || pop) begin
				out_q <= push_data;
			end else begin
				skd_q <= push_data;
			end
		end
	end

	assign full      = skd_vld_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q |-> out_vld_q)
		else $error("skid entry held without a result in the output register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("word pushed while skid entry occupied");

endmodule

>>> hw/rtl/delimited_token_splitter.sv
// top level: splits a byte stream at a multi-byte separator and trims blanks
// Usage:
//   Input channel (in_valid / in_stall) takes one word per cycle: data_byte with
//   has_byte, and last_item to close the value. Output channel (out_valid /
//   out_stall) gives a word for each separator that ends a non-empty trimmed
//   piece, and one for every word carrying last_item (end_of_value, any_piece).
//   Configuration: cfg_we with cfg_index selects sep_bytes or sep_length; write
//   only while no word is in flight.
//   A result is registered in the output register, else in the skid entry.
//   Throughput: one input word per cycle unless stalled; the separator compare
//   across the eight window cells and the trim search finish in the accepting
//   cycle. Stall: results wait in an output register plus one skid entry;
//   in_stall rises only while the skid entry is occupied.
//   Reset: separator is a single comma, window text marks and per-value
//   state cleared. Values longer than MAX_LEN bytes keep their first MAX_LEN
//   bytes and report overflow on every later result of that value.
module delimited_token_splitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  dts_pkg::reg_idx_t             cfg_index,
	input  logic [dts_pkg::SEPB_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          has_byte,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          piece_valid,
	output logic [dts_pkg::START_W-1:0]   piece_start,
	output logic [dts_pkg::PLEN_W-1:0]    piece_length,
	output logic                          end_of_value,
	output logic                          any_piece,
	output logic                          overflow
);
	import dts_pkg::*;

	logic [SEPB_W-1:0] sep_q;
	logic [LEN_W-1:0]  sep_len_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  ftp_q;
	logic [POS_W-1:0]  lte_q;
	logic [POS_W-1:0]  maf_q;
	logic              ts_q;
	logic              fa_q;
	logic              ovf_q;

	slot_t             prev_w [SEP_MAX];
	slot_t             cell_w [SEP_MAX];
	logic [7:0]        want_w [SEP_MAX];
	logic [SEP_MAX-1:0] eq_w;
	logic [SEP_MAX-1:0] need_w;
	logic [SEP_MAX-1:0] win_txt;

	logic [LEN_W-1:0]  len;
	logic              acc;
	logic              drop;
	logic              take;
	logic              blank;
	logic              clr;
	logic              hit;
	logic              piece;
	logic              emit;
	logic [POS_W-1:0]  pos_n;
	logic [POS_W-1:0]  ftp_n;
	logic [POS_W-1:0]  lte_c;
	logic [POS_W-1:0]  m_pos;
	logic [POS_W-1:0]  endv;
	logic [POS_W-1:0]  plen;
	logic              ts_n;
	logic              fa_n;
	logic              ovf_n;
	logic [LEN_W-1:0]  lo;
	logic              found;
	logic [SLOT_W-1:0] sel;
	logic              push_full;
	result_t           res_w;
	result_t           out_w;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q     <= SEP_BYTES_RST;
			sep_len_q <= SEP_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEP_BYTES:  sep_q     <= cfg_data;
				REG_SEP_LENGTH: sep_len_q <= cfg_data[LEN_W-1:0];
				default:        sep_q     <= sep_q;
			endcase
		end
	end

	assign len   = (sep_len_q > LEN_W'(SEP_MAX)) ? LEN_W'(SEP_MAX) : sep_len_q;
	assign acc   = in_valid && !in_stall;
	assign drop  = has_byte && (pos_q >= POS_W'(MAX_LEN));
	assign take  = acc && has_byte && !drop;
	assign blank = is_blank(data_byte);

	// window chain, slot 0 newest
	assign prev_w[0] = '{data: data_byte, txt: !blank};

	for (genvar s = 0; s < SEP_MAX; s++) begin : g_cell
		logic [LEN_W-1:0] k;
		assign k         = len - LEN_W'(1) - LEN_W'(s);
		assign want_w[s] = sep_q[8*k[SLOT_W-1:0] +: 8];
		assign need_w[s] = LEN_W'(s) < len;
		if (s > 0) begin : g_link
			assign prev_w[s] = cell_w[s-1];
		end
		assign win_txt[s] = take ? prev_w[s].txt : cell_w[s].txt;

		dts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (take),
			.clr_txt (clr),
			.need    (need_w[s]),
			.want    (want_w[s]),
			.prev    (prev_w[s]),
			.cur     (cell_w[s]),
			.eq      (eq_w[s])
		);
	end

	// trim tracking and match
	assign pos_n = pos_q + POS_W'(take);
	assign ts_n  = ts_q || (take && !blank);
	assign ftp_n = (take && !blank && !ts_q) ? pos_q : ftp_q;
	assign lte_c = (take && cell_w[SEP_MAX-1].txt) ? (pos_q - POS_W'(SEP_MAX - 1)) : lte_q;
	assign hit   = take && (len != '0) && ((pos_n - maf_q) >= POS_W'(len)) && (&eq_w);
	assign m_pos = pos_n - POS_W'(len);
	assign lo    = hit ? len : '0;

	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int s = SEP_MAX - 1; s >= 0; s--) begin
			if (win_txt[s] && (LEN_W'(s) >= lo)) begin
				found = 1'b1;
				sel   = SLOT_W'(s);
			end
		end
	end

	assign endv  = found ? (pos_n - POS_W'(sel)) : lte_c;
	assign plen  = endv - ftp_n;
	assign piece = hit ? (ts_n && (ftp_n < m_pos))
	                   : (acc && last_item && (len != '0) && ts_n);
	assign fa_n  = fa_q || piece;
	assign ovf_n = ovf_q || (acc && drop);
	assign emit  = acc && (piece || last_item);
	assign clr   = acc && (last_item || hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ftp_q <= '0;
			lte_q <= '0;
			maf_q <= '0;
			ts_q  <= 1'b0;
			fa_q  <= 1'b0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			priority if (last_item) begin
				pos_q <= '0;
				ftp_q <= '0;
				lte_q <= '0;
				maf_q <= '0;
				ts_q  <= 1'b0;
				fa_q  <= 1'b0;
				ovf_q <= 1'b0;
			end else if (hit) begin
				pos_q <= pos_n;
				ftp_q <= '0;
				lte_q <= '0;
				maf_q <= pos_n;
				ts_q  <= 1'b0;
				fa_q  <= fa_n;
				ovf_q <= ovf_n;
			end else begin
				pos_q <= pos_n;
				ftp_q <= ftp_n;
				lte_q <= lte_c;
				ts_q  <= ts_n;
				fa_q  <= fa_n;
				ovf_q <= ovf_n;
			end
		end
	end

	// result word
	assign res_w.piece_valid  = piece;
	assign res_w.piece_start  = piece ? ftp_n[START_W-1:0] : '0;
	assign res_w.piece_length = piece ? PLEN_W'(plen) : '0;
	assign res_w.end_of_value = last_item;
	assign res_w.any_piece    = last_item && fa_n;
	assign res_w.overflow     = ovf_n;

	dts_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (res_w),
		.full      (push_full),
		.out_valid (out_valid),
		.out_data  (out_w),
		.out_stall (out_stall)
	);

	assign in_stall     = push_full;
	assign piece_valid  = out_w.piece_valid;
	assign piece_start  = out_w.piece_start;
	assign piece_length = out_w.piece_length;
	assign end_of_value = out_w.end_of_value;
	assign any_piece    = out_w.any_piece;
	assign overflow     = out_w.overflow;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_LEN))
		else $error("byte position beyond value limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_item) |=> (pos_q == '0) && !ts_q && !fa_q && !ovf_q)
		else $error("per-value state not cleared after end of value");

	a_hit_resets_text: assert property (@(posedge clk) disable iff (!arst_n)
		(hit && !last_item) |=> !ts_q && (maf_q == pos_q) && (cell_w[0].txt == 1'b0))
		else $error("separator match did not restart the piece");

endmodule

>>> test/tb_top.sv
// testbench for the delimited token splitter: directed and random byte streams against a predictor
`timescale 1ns / 100ps
module tb_top;
	import dts_pkg::*;

	localparam int WATCH_LIMIT = 1000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	reg_idx_t          cfg_index = REG_SEP_BYTES;
	logic [SEPB_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte = 8'h00;
	logic              has_byte = 1'b0;
	logic              last_item = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b1;
	logic              piece_valid;
	logic [START_W-1:0] piece_start;
	logic [PLEN_W-1:0] piece_length;
	logic              end_of_value;
	logic              any_piece;
	logic              overflow;

	// predictor copy of configuration and per-value state
	logic [SEPB_W-1:0] sep_word;
	logic [LEN_W-1:0]  sep_len;
	logic [7:0]        win_byte [SEP_MAX];
	logic              win_blank [SEP_MAX];
	int                pos_count;
	int                seg_begin;
	int                text_first;
	int                text_end;
	int                match_from;
	logic              text_open;
	logic              seen_piece;
	logic              too_long;

	result_t           expected_words[$];
	result_t           oldest;
	int                errors = 0;
	int                words_sent = 0;
	int                quiet_cycles = 0;
	logic              calm = 1'b0;

	delimited_token_splitter uut (.*);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		errors++;
		if (errors <= 40)
			$display("error at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	function automatic void reset_value_state();
		for (int i = 0; i < SEP_MAX; i++) begin
			win_byte[i] = 8'h00;
			win_blank[i] = 1'b0;
		end
		pos_count = 0;
		seg_begin = 0;
		text_first = 0;
		text_end = 0;
		match_from = 0;
		text_open = 1'b0;
		seen_piece = 1'b0;
		too_long = 1'b0;
	endfunction

	// end of the last non-blank byte of the open piece below limit
	function automatic int text_stop_before(input int limit);
		int newest;
		int lo;
		int slot;
		newest = pos_count - 1;
		lo = text_first;
		if (newest >= SEP_MAX - 1 && newest - (SEP_MAX - 1) > lo)
			lo = newest - (SEP_MAX - 1);
		for (int q = limit; q > lo; q--) begin
			slot = newest - (q - 1);
			if (slot >= 0 && slot < SEP_MAX && !win_blank[slot])
				return q;
		end
		return text_end;
	endfunction

	function automatic void predict_split(input logic [7:0] b, input logic hb, input logic li);
		int      len;
		int      m;
		int      p_start;
		int      p_len;
		logic    have;
		logic    blank;
		logic    hit;
		logic    piece;
		result_t r;
		len = (sep_len > SEP_MAX) ? SEP_MAX : int'(sep_len);
		have = hb;
		piece = 1'b0;
		p_start = 0;
		p_len = 0;
		if (have && pos_count >= MAX_LEN) begin
			too_long = 1'b1;
			have = 1'b0;
		end
		if (have) begin
			blank = (b == CH_SPACE) || (b == CH_TAB);
			if (pos_count >= SEP_MAX && pos_count - SEP_MAX >= seg_begin &&
				!win_blank[SEP_MAX-1])
				text_end = pos_count - SEP_MAX + 1;
			for (int i = SEP_MAX - 1; i > 0; i--) begin
				win_byte[i] = win_byte[i-1];
				win_blank[i] = win_blank[i-1];
			end
			win_byte[0] = b;
			win_blank[0] = blank;
			pos_count++;
			if (!blank && !text_open) begin
				text_open = 1'b1;
				text_first = pos_count - 1;
			end
			if (len > 0 && pos_count - match_from >= len) begin
				hit = 1'b1;
				for (int k = 0; k < len; k++)
					if (win_byte[len-1-k] != sep_word[8*k +: 8])
						hit = 1'b0;
				if (hit) begin
					m = pos_count - len;
					if (text_open && text_first < m) begin
						piece = 1'b1;
						p_start = text_first;
						p_len = text_stop_before(m) - text_first;
					end
					seg_begin = pos_count;
					match_from = pos_count;
					text_open = 1'b0;
					text_first = 0;
					text_end = 0;
				end
			end
		end
		if (li && len > 0 && text_open && !piece) begin
			piece = 1'b1;
			p_start = text_first;
			p_len = text_stop_before(pos_count) - text_first;
		end
		if (piece)
			seen_piece = 1'b1;
		if (piece || li) begin
			r.piece_valid = piece;
			r.piece_start = piece ? START_W'(p_start) : '0;
			r.piece_length = piece ? PLEN_W'(p_len) : '0;
			r.end_of_value = li;
			r.any_piece = li && seen_piece;
			r.overflow = too_long;
			expected_words.push_back(r);
		end
		if (li)
			reset_value_state();
	endfunction

	task automatic send_word(input logic [7:0] b, input logic hb, input logic li);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_byte <= b;
		has_byte <= hb;
		last_item <= li;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (hb || li)
			words_sent++;
		predict_split(b, hb, li);
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b1, close && (i == s.len() - 1));
		if (close && s.len() == 0)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [SEPB_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SEP_BYTES)
			sep_word = d;
		else
			sep_len = d[LEN_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_separator(input logic [SEPB_W-1:0] bytes, input logic [LEN_W-1:0] len);
		settle();
		write_reg(REG_SEP_BYTES, bytes);
		write_reg(REG_SEP_LENGTH, SEPB_W'(len));
	endtask

	function automatic logic [7:0] sep_candidate();
		case ($urandom_range(0, 8))
			0: return 8'h2c;
			1: return 8'h3b;
			2: return 8'h3a;
			3: return CH_SPACE;
			4: return CH_TAB;
			5: return 8'h61;
			6: return 8'h00;
			7: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1: return sep_word[8*$urandom_range(0, SEP_MAX-1) +: 8];
			2: return CH_SPACE;
			3: return CH_TAB;
			4: return 8'($urandom);
			default: return 8'h61 + 8'($urandom_range(0, 2));
		endcase
	endfunction

	// mostly pieces with separators and blanks, some noise values
	task automatic send_random_value();
		int   n;
		int   len;
		int   cut;
		logic noisy;
		len = (sep_len > SEP_MAX) ? SEP_MAX : int'(sep_len);
		calm = ($urandom_range(0, 4) == 0);
		noisy = ($urandom_range(0, 9) == 0);
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 70) : $urandom_range(0, 20);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_word(8'($urandom), 1'b0, 1'b0);
			if (noisy)
				send_word(8'($urandom), 1'b1, 1'b0);
			else if (len > 0 && $urandom_range(0, 4) == 0) begin
				cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
				for (int k = 0; k < cut; k++)
					send_word(sep_word[8*k +: 8], 1'b1, 1'b0);
			end else
				send_word(pick_byte(), 1'b1, 1'b0);
		end
		if ($urandom_range(0, 1))
			send_word(8'($urandom), 1'b0, 1'b1);
		else
			send_word(noisy ? 8'($urandom) : pick_byte(), 1'b1, 1'b1);
		calm = 1'b0;
	endtask

	task automatic test_default_comma();
		send_word(8'($urandom), 1'b0, 1'b0);
		send_text("  ab ,\tc d\t,,  ,x", 1'b1);
		send_text("", 1'b1);
		send_text(" \t ", 1'b1);
	endtask

	task automatic test_zero_length();
		set_separator(SEPB_W'(64'h2c), 4'd0);
		send_text("a,b ", 1'b1);
	endtask

	task automatic test_blank_separator();
		set_separator(SEPB_W'(64'h2d2d20), 4'd3);
		send_text("x --y  -- z --", 1'b1);
		set_separator('1, 4'd8);
		send_text("ab", 1'b0);
		repeat (8) send_word(8'hff, 1'b1, 1'b0);
		send_text("c", 1'b0);
		repeat (7) send_word(8'hff, 1'b1, 1'b0);
		send_text("d", 1'b1);
	endtask

	task automatic test_clamped_length();
		set_separator(SEPB_W'(64'h0807060504030201), 4'd15);
		send_text("q", 1'b0);
		for (int k = 1; k <= SEP_MAX; k++)
			send_word(8'(k), 1'b1, 1'b0);
		send_text("r", 1'b1);
		set_separator(SEPB_W'(64'h0807060504030201), 4'd9);
		for (int k = 1; k <= SEP_MAX; k++)
			send_word(8'(k), 1'b1, 1'b0);
		send_text(" s", 1'b1);
	endtask

	task automatic test_overflow();
		set_separator(SEPB_W'(64'h2c), 4'd1);
		calm = 1'b1;
		for (int i = 0; i < MAX_LEN; i++)
			send_word(8'h61 + 8'($urandom_range(0, 2)), 1'b1, 1'b0);
		send_text("a b", 1'b1);
		for (int i = 0; i < MAX_LEN - 2; i++)
			send_word(8'h61 + 8'($urandom_range(0, 2)), 1'b1, 1'b0);
		send_text(",x y", 1'b1);
		calm = 1'b0;
	endtask

	task automatic test_random_values();
		logic [SEPB_W-1:0] bytes;
		logic [LEN_W-1:0]  len;
		int                goal;
		for (int phase = 0; phase < 10; phase++) begin
			for (int k = 0; k < SEP_MAX; k++)
				bytes[8*k +: 8] = sep_candidate();
			case (phase)
				0: len = 4'd1;
				1: len = 4'd2;
				2: len = 4'd3;
				3: begin
					len = 4'd8;
					bytes = '0;
				end
				4: begin
					len = 4'd15;
					bytes = '1;
				end
				5: begin
					len = 4'd0;
					bytes = {$urandom, $urandom};
				end
				6: len = 4'd4;
				7: len = 4'($urandom_range(0, 15));
				8: len = 4'd1;
				default: len = 4'($urandom_range(1, 8));
			endcase
			set_separator(bytes, len);
			goal = words_sent + ((phase == 5) ? 80 : 175);
			while (words_sent < goal)
				send_random_value();
		end
	endtask

	// output side raises out_stall for a random hold before each word, not at all while calm
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 6);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0)
				report_mismatch("word with nothing expected", 16'h0, 16'h0);
			else begin
				oldest = expected_words.pop_front();
				check_field("piece_valid", 16'(piece_valid), 16'(oldest.piece_valid));
				check_field("piece_start", 16'(piece_start), 16'(oldest.piece_start));
				check_field("piece_length", 16'(piece_length), 16'(oldest.piece_length));
				check_field("end_of_value", 16'(end_of_value), 16'(oldest.end_of_value));
				check_field("any_piece", 16'(any_piece), 16'(oldest.any_piece));
				check_field("overflow", 16'(overflow), 16'(oldest.overflow));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("delimited_token_splitter: mismatch");
			$finish;
		end
	end

	initial begin
		sep_word = SEP_BYTES_RST;
		sep_len = SEP_LENGTH_RST;
		reset_value_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_comma();
		test_zero_length();
		test_blank_separator();
		test_clamped_length();
		test_overflow();
		test_random_values();
		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("delimited_token_splitter: match");
		else
			$display("delimited_token_splitter: mismatch");
		$finish;
	end

endmodule

>>> delimited_token_splitter.f
hw/rtl/dts_pkg.sv
hw/rtl/dts_cell.sv
hw/rtl/dts_out_skid.sv
hw/rtl/delimited_token_splitter.sv
test/tb_top.sv
